// ===== design/ppsc_pkg.sv =====
package ppsc_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int VALUE_W      = 8;
    localparam int INDEX_W      = 3;
    localparam int MODE_W       = 3;

    // Stream widths: tdata on each side is padded with zeros to whole bytes.
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    localparam int DEF_MAX_COUNT       = 228;
    localparam int DEF_FAST_MAX_COUNT  = 229;
    localparam int DEF_FAST_STOP_COUNT = 230;

    localparam logic [VALUE_W-1:0] UNREAD_VALUE = 8'hFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_REINIT = 3'd0,
        MODE_START  = 3'd1,
        MODE_FAST   = 3'd2,
        MODE_SLOW   = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef logic [VALUE_W-1:0] value_t;

endpackage

// ===== design/paddle_pot_scan_counter_core.sv =====
// Channel  Signals                          Payload (lowest bit first)
// s        s_tvalid s_tready s_tuser s_tdata tuser: mode[2:0]
//                                            tdata: target_0..target_7, read_index, pad
// m        m_tvalid m_tready m_tdata         tdata: read_value, active_mask, scan_busy, pad
//
// One item is taken per cycle unless a stalled result holds it back; its result
// passes through the input register, then the scan update and the result register.
// The eight channel compares are evaluated in parallel within the single scan update stage.
// Reset is asynchronous and active low; it returns every channel to idle with
// latched readings of 0xff. A stalled result holds the pipeline; the input side
// keeps accepting as long as the result register frees up in the same cycle.
module paddle_pot_scan_counter_core #(
    parameter int MAX_COUNT       = ppsc_pkg::DEF_MAX_COUNT,
    parameter int FAST_MAX_COUNT  = ppsc_pkg::DEF_FAST_MAX_COUNT,
    parameter int FAST_STOP_COUNT = ppsc_pkg::DEF_FAST_STOP_COUNT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppsc_pkg::MODE_W-1:0]    s_tuser,  // mode
    input  logic [ppsc_pkg::IN_DATA_W-1:0] s_tdata,  // target_0..target_7, read_index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppsc_pkg::OUT_DATA_W-1:0] m_tdata  // read_value, active_mask, scan_busy
);
    import ppsc_pkg::*;

    localparam value_t MAX_C  = value_t'(MAX_COUNT);
    localparam value_t FMAX_C = value_t'(FAST_MAX_COUNT);
    localparam value_t FSTOP_C = value_t'(FAST_STOP_COUNT);

    // Input register
    logic                in_valid_reg;
    mode_t               in_mode_reg;
    value_t              in_target_reg [NUM_CHANNELS];
    logic [INDEX_W-1:0]  in_index_reg;

    // Scan state
    value_t              latched_reg [NUM_CHANNELS];
    value_t              latched_next [NUM_CHANNELS];
    value_t              pot_target_reg [NUM_CHANNELS];
    value_t              pot_target_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] active_reg;
    logic [NUM_CHANNELS-1:0] active_next;
    value_t              count_reg;
    value_t              count_next;
    logic                scanning_reg;
    logic                scanning_next;

    // Result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    value_t                read_value;

    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg  <= mode_t'(s_tuser);
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                in_target_reg[ch] <= s_tdata[VALUE_W*ch +: VALUE_W];
            end
            in_index_reg <= s_tdata[VALUE_W*NUM_CHANNELS +: INDEX_W];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        active_next   = active_reg;
        scanning_next = scanning_reg;
        latched_next  = latched_reg;
        pot_target_next = pot_target_reg;

        case (in_mode_reg)
            MODE_REINIT:
            begin
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                begin
                    latched_next[ch]    = UNREAD_VALUE;
                    pot_target_next[ch] = '0;
                end
                active_next   = '0;
                count_next    = '0;
                scanning_next = 1'b0;
            end
            MODE_START:
            begin
                for (int ch = 0; ch < NUM_CHANNELS; ch++)
                begin
                    latched_next[ch]    = '0;
                    pot_target_next[ch] = in_target_reg[ch];
                end
                active_next   = '1;
                count_next    = '0;
                scanning_next = 1'b1;
            end
            MODE_FAST:
            begin
                if (scanning_reg)
                begin
                    count_next = (count_reg < FSTOP_C) ? count_reg + 8'd1 : count_reg;
                    // Compares stop once the fast count has passed the slow maximum.
                    if (count_next <= MAX_C)
                    begin
                        for (int ch = 0; ch < NUM_CHANNELS; ch++)
                        begin
                            if (active_reg[ch] && count_next >= pot_target_reg[ch])
                            begin
                                latched_next[ch] = pot_target_reg[ch];
                                active_next[ch]  = 1'b0;
                            end
                        end
                        if (active_next == '0)
                        begin
                            scanning_next = 1'b0;
                        end
                    end
                    if (scanning_next)
                    begin
                        if (count_next == FMAX_C)
                        begin
                            for (int ch = 0; ch < NUM_CHANNELS; ch++)
                            begin
                                if (active_next[ch])
                                begin
                                    latched_next[ch] = FMAX_C;
                                end
                            end
                        end
                        if (count_next == FSTOP_C)
                        begin
                            active_next   = '0;
                            scanning_next = 1'b0;
                        end
                    end
                end
            end
            MODE_SLOW:
            begin
                if (scanning_reg)
                begin
                    count_next = (count_reg < MAX_C) ? count_reg + 8'd1 : count_reg;
                    for (int ch = 0; ch < NUM_CHANNELS; ch++)
                    begin
                        if (active_reg[ch] && count_next >= pot_target_reg[ch])
                        begin
                            latched_next[ch] = pot_target_reg[ch];
                            active_next[ch]  = 1'b0;
                        end
                    end
                    if (active_next == '0)
                    begin
                        scanning_next = 1'b0;
                    end
                    else if (count_next == MAX_C)
                    begin
                        // Channels that never matched read the full-scale count.
                        for (int ch = 0; ch < NUM_CHANNELS; ch++)
                        begin
                            if (active_next[ch])
                            begin
                                latched_next[ch] = MAX_C;
                            end
                        end
                        active_next   = '0;
                        scanning_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (active_next[in_index_reg])
        begin
            read_value = (count_next < FMAX_C) ? count_next : FMAX_C;
        end
        else
        begin
            read_value = latched_next[in_index_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                latched_reg[ch]    <= UNREAD_VALUE;
                pot_target_reg[ch] <= '0;
            end
            active_reg    <= '0;
            count_reg     <= '0;
            scanning_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                latched_reg    <= latched_next;
                pot_target_reg <= pot_target_next;
                active_reg     <= active_next;
                count_reg      <= count_next;
                scanning_reg   <= scanning_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, scanning_next, active_next, read_value};
        end
    end

`ifndef ASSERT_OFF
    // A scan is in progress exactly while some channel is still active.
    a_busy_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        scanning_reg == (active_reg != '0))
        else $error("scan flag disagrees with active channels");

    a_count_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FSTOP_C)
        else $error("scan counter passed the fast stop count");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[16] == (out_data_reg[15:8] != '0)))
        else $error("result busy flag disagrees with its active mask");

    a_stall_keeps_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("input item dropped while the result was stalled");
`endif

endmodule
